// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the scorer RTL.
// Depends on i_clk and i_rst_n being present in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property checked on every clock outside of reset.
`define CHK_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Antecedent in one cycle implies consequent in the next.
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CHK_ASSERT(label, prop, msg)
`define CHK_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- hdl/ngsg_pkg.sv -----
// Shared types and constants for the n-gram string gibberish scorer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package ngsg_pkg;

    localparam int ADDR_W        = 14;
    localparam int WEIGHT_BITS   = 32;
    localparam int SCORE_W       = 40;
    localparam int LEN_W         = 5;
    localparam int ALPHABET_SIZE = 118;

    localparam int MAX_SCORED_LENGTH = 16;
    localparam int MIN_SCORED_LENGTH = 4;

    localparam int LENGTH_INDEX_I = 2 * ALPHABET_SIZE + ALPHABET_SIZE * ALPHABET_SIZE;
    localparam int WEIGHT_DEPTH_I = LENGTH_INDEX_I + 3;

    localparam logic [ADDR_W-1:0] ALPHA_A        = ADDR_W'(ALPHABET_SIZE);
    localparam logic [ADDR_W-1:0] BIGRAM_BASE    = ADDR_W'(ALPHABET_SIZE);
    localparam logic [ADDR_W-1:0] LENGTH_INDEX   = ADDR_W'(LENGTH_INDEX_I);
    localparam logic [ADDR_W-1:0] NONLATIN_INDEX = ADDR_W'(LENGTH_INDEX_I + 1);
    localparam logic [ADDR_W-1:0] DISTINCT_INDEX = ADDR_W'(LENGTH_INDEX_I + 2);
    localparam logic [ADDR_W-1:0] WEIGHT_DEPTH   = ADDR_W'(WEIGHT_DEPTH_I);

    localparam logic [7:0] FIRST_PRINTABLE = 8'h09;
    localparam logic [7:0] LAST_PRINTABLE  = 8'h7E;

    localparam logic [LEN_W-1:0] LEN_SAT      = LEN_W'(MAX_SCORED_LENGTH + 1);
    localparam logic [LEN_W-1:0] LEN_MIN      = LEN_W'(MIN_SCORED_LENGTH);
    localparam logic [LEN_W-1:0] LEN_MAX      = LEN_W'(MAX_SCORED_LENGTH);
    localparam logic [LEN_W-1:0] DISTINCT_SAT = {LEN_W{1'b1}};

    localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic OP_WEIGHT = 1'b0;
    localparam logic OP_BYTE   = 1'b1;

    typedef enum logic [1:0] {
        VK_SCORED = 2'd0,
        VK_SHORT  = 2'd1,
        VK_LONG   = 2'd2
    } t_verdict;

    typedef enum logic [1:0] {
        STEP_BIGRAM,
        STEP_UNIGRAM,
        STEP_LENGTH,
        STEP_DISTINCT
    } t_step;

    // One classified transaction, from the front end to the back end.
    typedef struct packed {
        logic                   op;
        logic                   we;
        logic [ADDR_W-1:0]      addr_a;
        logic [ADDR_W-1:0]      addr_b;
        logic                   has_bigram;
        logic                   first;
        logic                   last;
        t_verdict               kind;
        logic [LEN_W-1:0]       len;
        logic [LEN_W-1:0]       distinct;
        logic [WEIGHT_BITS-1:0] wdata;
    } t_job;

    // What to do with a weight when it comes out of memory.
    typedef struct packed {
        logic             first;
        logic             last_res;
        logic [LEN_W-1:0] factor;
        t_verdict         kind;
        logic [LEN_W-1:0] len;
    } t_tag;

endpackage
`default_nettype wire

// ----- hdl/ngsg_front.sv -----
// Front end: accepts transactions, tracks per-string state and builds jobs.
// Depends on ngsg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ngsg_front (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    input  wire logic                             i_op,
    input  wire logic [ngsg_pkg::ADDR_W-1:0]      i_weight_index,
    input  wire logic [31:0]                      i_weight_value,
    input  wire logic [7:0]                       i_string_byte,
    input  wire logic                             i_last,
    input  wire logic                             i_q_full,
    output      logic                             o_push,
    output      ngsg_pkg::t_job                   o_job
);

    logic [255:0]                   r_seen, n_seen;
    logic [ngsg_pkg::LEN_W-1:0]     r_count, n_count;
    logic [ngsg_pkg::LEN_W-1:0]     r_distinct, n_distinct;
    logic [6:0]                     r_prev_off, n_prev_off;
    logic                           r_prev_pr, n_prev_pr;

    logic                           accept;
    logic                           pr;
    logic [6:0]                     cur;
    logic [ngsg_pkg::LEN_W-1:0]     cnt_inc;
    logic [ngsg_pkg::LEN_W-1:0]     dist_inc;

    always_comb begin
        accept   = i_valid && !i_q_full;
        pr       = (i_string_byte >= ngsg_pkg::FIRST_PRINTABLE) &&
                   (i_string_byte <= ngsg_pkg::LAST_PRINTABLE);
        cur      = 7'(i_string_byte - ngsg_pkg::FIRST_PRINTABLE);
        cnt_inc  = (r_count < ngsg_pkg::LEN_SAT) ? r_count + 1'b1 : r_count;
        dist_inc = (r_seen[i_string_byte] || r_distinct == ngsg_pkg::DISTINCT_SAT) ?
                   r_distinct : r_distinct + 1'b1;

        o_push            = accept;
        o_job.op          = i_op;
        o_job.we          = (i_op == ngsg_pkg::OP_WEIGHT) &&
                            (i_weight_index < ngsg_pkg::WEIGHT_DEPTH);
        o_job.wdata       = i_weight_value[ngsg_pkg::WEIGHT_BITS-1:0];
        o_job.addr_b      = ngsg_pkg::BIGRAM_BASE + ngsg_pkg::ADDR_W'(r_prev_off) +
                            ngsg_pkg::ALPHA_A * ngsg_pkg::ADDR_W'(cur);
        o_job.has_bigram  = pr && r_prev_pr;
        o_job.first       = (r_count == '0);
        o_job.last        = i_last;
        o_job.len         = cnt_inc;
        o_job.distinct    = dist_inc;
        if (i_op == ngsg_pkg::OP_WEIGHT) begin
            o_job.addr_a = i_weight_index;
        end else if (pr) begin
            o_job.addr_a = ngsg_pkg::ADDR_W'(cur);
        end else begin
            o_job.addr_a = ngsg_pkg::NONLATIN_INDEX;
        end
        if (cnt_inc < ngsg_pkg::LEN_MIN) begin
            o_job.kind = ngsg_pkg::VK_SHORT;
        end else if (cnt_inc > ngsg_pkg::LEN_MAX) begin
            o_job.kind = ngsg_pkg::VK_LONG;
        end else begin
            o_job.kind = ngsg_pkg::VK_SCORED;
        end

        n_seen     = r_seen;
        n_count    = r_count;
        n_distinct = r_distinct;
        n_prev_off = r_prev_off;
        n_prev_pr  = r_prev_pr;
        if (accept && i_op == ngsg_pkg::OP_BYTE) begin
            if (i_last) begin
                // string done: start clean for the next one
                n_seen     = '0;
                n_count    = '0;
                n_distinct = '0;
                n_prev_off = '0;
                n_prev_pr  = 1'b0;
            end else begin
                n_seen[i_string_byte] = 1'b1;
                n_count    = cnt_inc;
                n_distinct = dist_inc;
                n_prev_off = cur;
                n_prev_pr  = pr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen     <= '0;
            r_count    <= '0;
            r_distinct <= '0;
            r_prev_off <= '0;
            r_prev_pr  <= 1'b0;
        end else begin
            r_seen     <= n_seen;
            r_count    <= n_count;
            r_distinct <= n_distinct;
            r_prev_off <= n_prev_off;
            r_prev_pr  <= n_prev_pr;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/ngsg_queue.sv -----
// Short job queue between the front end and the back end.
// Depends on ngsg_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ngsg_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire ngsg_pkg::t_job i_job,
    output      logic           o_full,
    output      logic           o_valid,
    output      ngsg_pkg::t_job o_job,
    input  wire logic           i_pop
);

    ngsg_pkg::t_job                 r_entry [ngsg_pkg::QDEPTH];
    logic [ngsg_pkg::QPTR_W-1:0]    r_wr_ptr, r_rd_ptr;
    logic [ngsg_pkg::QCNT_W-1:0]    r_count;

    assign o_full  = (r_count == ngsg_pkg::QCNT_W'(ngsg_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `CHK_ASSERT(a_q_bound, r_count <= ngsg_pkg::QCNT_W'(ngsg_pkg::QDEPTH), "queue overfilled")
    `CHK_ASSERT(a_q_no_underrun, !(i_pop && r_count == '0), "pop from empty queue")

endmodule
`default_nettype wire

// ----- hdl/ngsg_back.sv -----
// Back end: weight memory, read sequencer, saturating accumulator, result register.
// Depends on ngsg_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ngsg_back (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_bias_we,
    input  wire logic [31:0]                       i_bias_data,
    input  wire logic                              i_q_valid,
    input  wire ngsg_pkg::t_job                    i_job,
    output      logic                              o_pop,
    output      logic                              o_valid,
    input  wire logic                              i_stall,
    output      logic signed [ngsg_pkg::SCORE_W-1:0] o_score,
    output      logic                              o_interesting,
    output      logic [1:0]                        o_verdict_kind,
    output      logic [ngsg_pkg::LEN_W-1:0]        o_string_length
);

    logic [ngsg_pkg::WEIGHT_BITS-1:0]      r_wmem [ngsg_pkg::WEIGHT_DEPTH_I];
    logic signed [ngsg_pkg::WEIGHT_BITS-1:0] r_rdata;
    logic signed [31:0]                    r_bias;
    logic signed [ngsg_pkg::SCORE_W-1:0]   r_acc;

    ngsg_pkg::t_step                       r_step, n_step, cur_step;
    ngsg_pkg::t_tag                        r_tag, tag;
    logic                                  r_tag_valid;

    logic                                  r_out_valid;
    logic signed [ngsg_pkg::SCORE_W-1:0]   r_score;
    logic                                  r_interesting;
    ngsg_pkg::t_verdict                    r_kind;
    logic [ngsg_pkg::LEN_W-1:0]            r_len;

    logic                                  issue, wr_en, out_free, more;
    logic [ngsg_pkg::ADDR_W-1:0]           rd_addr;

    logic signed [ngsg_pkg::SCORE_W-1:0]   base;
    logic signed [ngsg_pkg::WEIGHT_BITS+5:0] prod;
    logic signed [ngsg_pkg::SCORE_W:0]     sum;
    logic signed [ngsg_pkg::SCORE_W-1:0]   sat;

    // ---------------- read sequencer ----------------
    always_comb begin
        out_free = (!r_out_valid || !i_stall) && !(r_tag_valid && r_tag.last_res);
        cur_step = (r_step == ngsg_pkg::STEP_BIGRAM && !i_job.has_bigram) ?
                   ngsg_pkg::STEP_UNIGRAM : r_step;
        more     = i_job.last && (i_job.kind == ngsg_pkg::VK_SCORED);

        issue        = 1'b0;
        wr_en        = 1'b0;
        o_pop        = 1'b0;
        n_step       = r_step;
        rd_addr      = i_job.addr_a;
        tag.first    = 1'b0;
        tag.last_res = 1'b0;
        tag.factor   = ngsg_pkg::LEN_W'(1);
        tag.kind     = i_job.kind;
        tag.len      = i_job.len;

        if (i_q_valid) begin
            if (i_job.op == ngsg_pkg::OP_WEIGHT) begin
                wr_en = i_job.we;
                o_pop = 1'b1;
            end else begin
                case (cur_step)
                    ngsg_pkg::STEP_BIGRAM: begin
                        rd_addr   = i_job.addr_b;
                        tag.first = i_job.first;
                        issue     = 1'b1;
                        n_step    = ngsg_pkg::STEP_UNIGRAM;
                    end
                    ngsg_pkg::STEP_UNIGRAM: begin
                        rd_addr      = i_job.addr_a;
                        tag.first    = i_job.first && !i_job.has_bigram;
                        tag.last_res = i_job.last && !more;
                        issue        = !tag.last_res || out_free;
                        if (issue) begin
                            if (more) begin
                                n_step = ngsg_pkg::STEP_LENGTH;
                            end else begin
                                o_pop  = 1'b1;
                                n_step = ngsg_pkg::STEP_BIGRAM;
                            end
                        end
                    end
                    ngsg_pkg::STEP_LENGTH: begin
                        rd_addr    = ngsg_pkg::LENGTH_INDEX;
                        tag.factor = i_job.len;
                        issue      = 1'b1;
                        n_step     = ngsg_pkg::STEP_DISTINCT;
                    end
                    ngsg_pkg::STEP_DISTINCT: begin
                        rd_addr      = ngsg_pkg::DISTINCT_INDEX;
                        tag.factor   = i_job.distinct;
                        tag.last_res = 1'b1;
                        issue        = out_free;
                        if (issue) begin
                            o_pop  = 1'b1;
                            n_step = ngsg_pkg::STEP_BIGRAM;
                        end
                    end
                    default: begin
                        n_step = ngsg_pkg::STEP_BIGRAM;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ngsg_pkg::STEP_BIGRAM;
        end else begin
            r_step <= n_step;
        end
    end

    // ---------------- weight memory ----------------
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_wmem[i_job.addr_a] <= i_job.wdata;
        end
        if (issue) begin
            r_rdata <= $signed(r_wmem[rd_addr]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_tag <= tag;
        end
    end

    // ---------------- accumulate ----------------
    always_comb begin
        base = r_tag.first ? ngsg_pkg::SCORE_W'(r_bias) : r_acc;
        prod = r_rdata * $signed({1'b0, r_tag.factor});
        sum  = $signed((ngsg_pkg::SCORE_W+1)'(base)) + $signed((ngsg_pkg::SCORE_W+1)'(prod));
        if (sum[ngsg_pkg::SCORE_W] != sum[ngsg_pkg::SCORE_W-1]) begin
            sat = sum[ngsg_pkg::SCORE_W] ? ngsg_pkg::SCORE_MIN : ngsg_pkg::SCORE_MAX;
        end else begin
            sat = sum[ngsg_pkg::SCORE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias      <= '0;
            r_acc       <= '0;
            r_tag_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_bias_we) begin
                r_bias <= i_bias_data;
            end
            r_tag_valid <= issue;
            if (r_tag_valid) begin
                r_acc <= sat;
            end
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_tag_valid && r_tag.last_res) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_tag_valid && r_tag.last_res) begin
            r_kind <= r_tag.kind;
            r_len  <= r_tag.len;
            case (r_tag.kind)
                ngsg_pkg::VK_SCORED: begin
                    r_score       <= sat;
                    r_interesting <= !sat[ngsg_pkg::SCORE_W-1] && (sat != '0);
                end
                ngsg_pkg::VK_LONG: begin
                    r_score       <= '0;
                    r_interesting <= 1'b1;
                end
                default: begin
                    r_score       <= '0;
                    r_interesting <= 1'b0;
                end
            endcase
        end
    end

    assign o_valid         = r_out_valid;
    assign o_score         = r_score;
    assign o_interesting   = r_interesting;
    assign o_verdict_kind  = r_kind;
    assign o_string_length = r_len;

    `CHK_ASSERT(a_no_overrun, !(r_tag_valid && r_tag.last_res && r_out_valid && i_stall), "result lost in output register")
    `CHK_ASSERT(a_rw_excl, !(wr_en && issue), "weight write and read in one cycle")
    `CHK_NEXT(a_res_spacing, r_tag_valid && r_tag.last_res, !(r_tag_valid && r_tag.last_res), "results back to back")

endmodule
`default_nettype wire

// ----- hdl/ngram_string_gibberish_scorer_unit.sv -----
// Scores extracted strings, one byte per input transaction, with a linear n-gram model
// held in a 14163-entry weight memory loaded through op 0 transactions. A string byte
// needs a bigram and a unigram read when it and the byte before it are both in
// 0x09..0x7E, else a unigram read alone. The last byte of a string of scored length
// adds reads of the length and distinct-count weights, all on the single read port of
// the weight memory. A four-deep job queue decouples intake from scoring, so input
// keeps flowing while a result waits in the output register, until the queue fills. A
// result passes the read data and tag registers before the output register. Weights
// read before they were written give an undefined score. No clearing pass after reset.
// Depends on ngsg_pkg, ngsg_front, ngsg_queue and ngsg_back.
`timescale 1ns / 1ps
`default_nettype none
module ngram_string_gibberish_scorer_unit (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_bias_we,
    input  wire logic signed [31:0]   i_bias_data,
    input  wire logic                 i_valid,
    output      logic                 o_stall,
    input  wire logic                 i_op,
    input  wire logic [13:0]          i_weight_index,
    input  wire logic signed [31:0]   i_weight_value,
    input  wire logic [7:0]           i_string_byte,
    input  wire logic                 i_last,
    output      logic                 o_valid,
    input  wire logic                 i_stall,
    output      logic signed [39:0]   o_score,
    output      logic                 o_interesting,
    output      logic [1:0]           o_verdict_kind,
    output      logic [4:0]           o_string_length
);

    logic           push, q_full, q_valid, pop;
    ngsg_pkg::t_job push_job, head_job;

    assign o_stall = q_full;

    ngsg_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_op           (i_op),
        .i_weight_index (i_weight_index),
        .i_weight_value (i_weight_value),
        .i_string_byte  (i_string_byte),
        .i_last         (i_last),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_job          (push_job)
    );

    ngsg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (head_job),
        .i_pop   (pop)
    );

    ngsg_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_bias_we       (i_bias_we),
        .i_bias_data     (i_bias_data),
        .i_q_valid       (q_valid),
        .i_job           (head_job),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_score         (o_score),
        .o_interesting   (o_interesting),
        .o_verdict_kind  (o_verdict_kind),
        .o_string_length (o_string_length)
    );

endmodule
`default_nettype wire
